FILE: design/utf8_to_ucs2_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_TO_UCS2_DECODER_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_MACROS_SVH

// Same-cycle implication, checked on clk, idle during reset.
`define U8U2_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// Next-cycle implication, checked on clk, idle during reset.
`define U8U2_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

FILE: design/u8u2_pkg.sv
// Types and constants of the UTF-8 to UCS-2 decoder.
package u8u2_pkg;

    typedef logic [1:0]  pending_t;
    typedef logic [15:0] unit_t;

    // Continuation bytes still expected after each kind of lead byte.
    localparam pending_t SEQ2_PENDING = 2'd1;
    localparam pending_t SEQ3_PENDING = 2'd2;
    localparam pending_t SKIP_PENDING = 2'd3;
    localparam pending_t LEAD_PENDING = 2'd0;

    // Replacement for a bad lead byte: ASCII question mark.
    localparam unit_t REPLACEMENT_UNIT = 16'h003F;
    localparam unit_t NUL_UNIT         = 16'h0000;

    localparam logic [7:0] NUL_BYTE = 8'h00;

endpackage

FILE: design/utf8_to_ucs2_decoder.sv
// UTF-8 to UCS-2 decoder: byte stream in, 16-bit code units out.
//
// One UTF-8 byte per request goes in, at most one 16-bit code unit per
// request comes out, and a byte can be accepted on every clock while
// in_stall is low. ASCII bytes pass straight through. 110xxxxx opens
// a two-byte sequence and 1110xxxx a three-byte one; the following bytes
// are taken as continuation bytes without checking, their low six bits
// shifted into the partial code unit, and the unit appears once the last
// byte is in. Any other lead byte yields '?' right away and the next three
// bytes are dropped. A zero byte always ends the string: it yields code unit
// 0 with end_of_string high and returns the decoder to the lead position,
// even in the middle of a sequence or a skip (the partial sequence is lost).
// Timing: the decode is one level of classification plus a shift-or between
// the decode state registers and the result register, so a byte's code unit
// is registered in the result or skid register at the edge that takes the
// byte, one byte per cycle while in_stall is low. A two-entry output (result
// plus skid register) decouples the sides: in_stall rises only when both
// are full, so input keeps flowing while a result waits to be taken.
module utf8_to_ucs2_decoder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        end_of_string
);

    // Decode state
    u8u2_pkg::pending_t pending_reg, pending_next;
    logic               skipping_reg, skipping_next;
    u8u2_pkg::unit_t    partial_reg, partial_next;

    // Result of the byte on the input this cycle
    logic               res_valid;
    u8u2_pkg::unit_t    res_unit;
    logic               res_eos;
    u8u2_pkg::unit_t    merged;
    u8u2_pkg::pending_t pending_dec;

    // Output register and skid register
    logic               out_valid_reg, out_valid_next;
    u8u2_pkg::unit_t    out_unit_reg, out_unit_next;
    logic               out_eos_reg, out_eos_next;
    logic               skid_valid_reg, skid_valid_next;
    u8u2_pkg::unit_t    skid_unit_reg, skid_unit_next;
    logic               skid_eos_reg, skid_eos_next;

    logic               in_fire;
    logic               out_fire;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    assign out_valid     = out_valid_reg;
    assign code_unit     = out_unit_reg;
    assign end_of_string = out_eos_reg;

    // Byte decode
    always_comb
    begin
        pending_dec   = pending_reg - 2'd1;
        merged        = partial_reg
                      | ({10'd0, in_byte[5:0]} << ((pending_reg == u8u2_pkg::SEQ3_PENDING)
                                                   ? 4'd6 : 4'd0));
        pending_next  = pending_reg;
        skipping_next = skipping_reg;
        partial_next  = partial_reg;
        res_valid     = 1'b0;
        res_unit      = u8u2_pkg::NUL_UNIT;
        res_eos       = 1'b0;

        if (in_byte == u8u2_pkg::NUL_BYTE)
        begin
            // terminator: drop anything pending
            pending_next  = u8u2_pkg::LEAD_PENDING;
            skipping_next = 1'b0;
            partial_next  = u8u2_pkg::NUL_UNIT;
            res_valid     = 1'b1;
            res_eos       = 1'b1;
        end
        else if (pending_reg != u8u2_pkg::LEAD_PENDING)
        begin
            pending_next = pending_dec;
            if (skipping_reg)
            begin
                if (pending_dec == u8u2_pkg::LEAD_PENDING)
                begin
                    skipping_next = 1'b0;
                end
            end
            else if (pending_dec == u8u2_pkg::LEAD_PENDING)
            begin
                partial_next = u8u2_pkg::NUL_UNIT;
                res_valid    = 1'b1;
                res_unit     = merged;
            end
            else
            begin
                partial_next = merged;
            end
        end
        else
        begin
            case (in_byte) inside
                8'b0???_????:
                begin
                    res_valid = 1'b1;
                    res_unit  = {8'd0, in_byte};
                end
                8'b110?_????:
                begin
                    partial_next = {5'd0, in_byte[4:0], 6'd0};
                    pending_next = u8u2_pkg::SEQ2_PENDING;
                end
                8'b1110_????:
                begin
                    partial_next = {in_byte[3:0], 12'd0};
                    pending_next = u8u2_pkg::SEQ3_PENDING;
                end
                default:
                begin
                    // invalid lead: '?' now, then swallow three bytes
                    pending_next  = u8u2_pkg::SKIP_PENDING;
                    skipping_next = 1'b1;
                    partial_next  = u8u2_pkg::NUL_UNIT;
                    res_valid     = 1'b1;
                    res_unit      = u8u2_pkg::REPLACEMENT_UNIT;
                end
            endcase
        end
    end

    // Output register / skid steering
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_unit_next   = out_unit_reg;
        out_eos_next    = out_eos_reg;
        skid_valid_next = skid_valid_reg;
        skid_unit_next  = skid_unit_reg;
        skid_eos_next   = skid_eos_reg;

        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_unit_next   = skid_unit_reg;
                out_eos_next    = skid_eos_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire && res_valid;
                out_unit_next  = res_unit;
                out_eos_next   = res_eos;
            end
        end
        else if (in_fire && res_valid)
        begin
            // result register held: park the new result in the skid
            skid_valid_next = 1'b1;
            skid_unit_next  = res_unit;
            skid_eos_next   = res_eos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= u8u2_pkg::LEAD_PENDING;
            skipping_reg   <= 1'b0;
            partial_reg    <= u8u2_pkg::NUL_UNIT;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                pending_reg  <= pending_next;
                skipping_reg <= skipping_next;
                partial_reg  <= partial_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_unit_reg  <= out_unit_next;
        out_eos_reg   <= out_eos_next;
        skid_unit_reg <= skid_unit_next;
        skid_eos_reg  <= skid_eos_next;
    end

`include "utf8_to_ucs2_decoder_macros.svh"

    `U8U2_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `U8U2_ASSERT_NOW(a_skip_has_pending, skipping_reg,
                     pending_reg != u8u2_pkg::LEAD_PENDING)
    `U8U2_ASSERT_NOW(a_eos_unit_zero, out_valid_reg && out_eos_reg,
                     out_unit_reg == u8u2_pkg::NUL_UNIT)
    `U8U2_ASSERT_NEXT(a_nul_to_lead, in_fire && (in_byte == u8u2_pkg::NUL_BYTE),
                      (pending_reg == u8u2_pkg::LEAD_PENDING) && !skipping_reg)

endmodule
